>>> src/bic_pkg.sv
`default_nettype none

package bic_pkg;

  // field widths
  localparam int CFG_W       = 9;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 6;
  localparam int COUNT_W     = 17;
  localparam int BIN_W       = 7;
  localparam int NUM_COLORS  = 64;
  localparam int CFG_INDEX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   SIZE_RESET = 9'd256;

  // request codes
  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_READ  = 2'd1,
    REQ_START = 2'd2
  } req_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic take_pix;
    logic take_read;
    logic clear_hist;
    logic classify;
    logic write_hist;
    logic load_b;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_complete;
    logic row_nonzero;
    logic last_row;
    logic need_b;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> src/border_interior_color_histogram_top.sv
// channel   direction  handshake             payload
// request   in         req_valid / req_stall req_type, chan0, chan1, chan2, bin_select
// result    out        res_valid / res_stall bin_count, bin_index, frame_done
// config    in         cfg_write             cfg_index, cfg_data
//
// one transaction at a time; a start or an ignored request completes while the controller stays idle
// a pixel is classified and then gets zero, one or two histogram updates, each a read
// then a write, as a read-modify-write of the single-port histogram memory
// a bin read passes the read-wait and read-done states; its result waits in an output
// register while new requests are taken, and a second read holds until the register is free
// synchronous reset clears control state and the bin valid bits; no clearing pass
`default_nettype none

module border_interior_color_histogram_top import bic_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire logic [1:0]             req_type,
  input  wire logic [CHAN_W-1:0]      chan0,
  input  wire logic [CHAN_W-1:0]      chan1,
  input  wire logic [CHAN_W-1:0]      chan2,
  input  wire logic [BIN_W-1:0]       bin_select,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output logic [COUNT_W-1:0]          bin_count,
  output logic [BIN_W-1:0]            bin_index,
  output logic                        frame_done
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // line buffers, histograms and result register
  bic_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chan0      (chan0),
    .chan1      (chan1),
    .chan2      (chan2),
    .bin_select (bin_select),
    .cmd        (cmd),
    .sts        (sts),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .bin_count  (bin_count),
    .bin_index  (bin_index),
    .frame_done (frame_done)
  );

endmodule

`default_nettype wire

>>> src/bic_ctrl.sv
`default_nettype none

module bic_ctrl import bic_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic [1:0] req_type,
  output logic            req_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CLASSIFY = 8'b0000_0010,
    ST_HREAD_A  = 8'b0000_0100,
    ST_HWRITE_A = 8'b0000_1000,
    ST_HREAD_B  = 8'b0001_0000,
    ST_HWRITE_B = 8'b0010_0000,
    ST_RD_WAIT  = 8'b0100_0000,
    ST_RD_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // new transactions only between items
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_PIXEL: begin
              if (!sts.frame_complete) begin
                cmd.take_pix = 1'b1;
                state_next   = ST_CLASSIFY;
              end
            end
            REQ_READ: begin
              cmd.take_read = 1'b1;
              state_next    = ST_RD_WAIT;
            end
            REQ_START: begin
              cmd.clear_hist = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        if (sts.row_nonzero) begin
          state_next = ST_HREAD_A;
        end else if (sts.last_row) begin
          state_next = ST_HREAD_B;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_HREAD_A: begin
        state_next = ST_HWRITE_A;
      end
      ST_HWRITE_A: begin
        cmd.write_hist = 1'b1;
        if (sts.need_b) begin
          cmd.load_b = 1'b1;
          state_next = ST_HREAD_B;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_HREAD_B: begin
        state_next = ST_HWRITE_B;
      end
      ST_HWRITE_B: begin
        cmd.write_hist = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_RD_WAIT: begin
        state_next = ST_RD_DONE;
      end
      ST_RD_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> src/bic_datapath.sv
`default_nettype none

module bic_datapath import bic_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic [CHAN_W-1:0]      chan0,
  input  wire logic [CHAN_W-1:0]      chan1,
  input  wire logic [CHAN_W-1:0]      chan2,
  input  wire logic [BIN_W-1:0]       bin_select,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output logic [COUNT_W-1:0]          bin_count,
  output logic [BIN_W-1:0]            bin_index,
  output logic                        frame_done
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W = (POS_W + 1 > CFG_W) ? POS_W + 1 : CFG_W;
  localparam int WCAP  = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam int HCAP  = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
  localparam logic [CFG_W-1:0] WCAP_V = CFG_W'(WCAP);
  localparam logic [CFG_W-1:0] HCAP_V = CFG_W'(HCAP);
  localparam int HIST_DEPTH = 2 * NUM_COLORS;

  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  logic [CFG_W-1:0]   eff_w;
  logic [CFG_W-1:0]   eff_h;
  logic [COL_W-1:0]   col_pos;
  logic [ROW_W-1:0]   row_pos;
  logic               frame_complete;
  logic [CMP_W-1:0]   col_inc;
  logic [CMP_W-1:0]   row_inc;
  logic [COL_W-1:0]   col_right;
  logic               col_more;
  logic               row_more;

  logic [COLOR_W-1:0] upper_line  [MAX_WIDTH];
  logic [COLOR_W-1:0] middle_line [MAX_WIDTH];
  logic [COLOR_W-1:0] mid_q;
  logic [COLOR_W-1:0] right_q;
  logic [COLOR_W-1:0] up_q;
  logic [COLOR_W-1:0] left_mid;
  logic [COLOR_W-1:0] pix;
  logic               inner;
  logic [BIN_W-1:0]   addr_a;
  logic [BIN_W-1:0]   addr_b;
  logic [BIN_W-1:0]   addr_b_q;
  logic               need_b;

  logic [COUNT_W-1:0]    hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_valid;
  logic [BIN_W-1:0]      hist_addr;
  logic [COUNT_W-1:0]    hist_q;
  logic                  hist_qv;
  logic [COUNT_W-1:0]    hist_cur;
  logic [COUNT_W-1:0]    hist_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIZE_RESET;
      frame_height <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size: zero reads as one, capped at the line length
  always_comb begin
    if (frame_width == '0) begin
      eff_w = CFG_W'(1);
    end else if (frame_width > WCAP_V) begin
      eff_w = WCAP_V;
    end else begin
      eff_w = frame_width;
    end
    if (frame_height == '0) begin
      eff_h = CFG_W'(1);
    end else if (frame_height > HCAP_V) begin
      eff_h = HCAP_V;
    end else begin
      eff_h = frame_height;
    end
  end

  // position compares
  assign col_inc   = CMP_W'(col_pos) + CMP_W'(1);
  assign row_inc   = CMP_W'(row_pos) + CMP_W'(1);
  assign col_right = col_inc[COL_W-1:0];
  assign col_more  = col_inc < CMP_W'(eff_w);
  assign row_more  = row_inc < CMP_W'(eff_h);

  // raster position, restarted by start transaction or register write
  always_ff @(posedge clk) begin
    if (rst || cfg_write || cmd.clear_hist) begin
      col_pos        <= '0;
      row_pos        <= '0;
      frame_complete <= 1'b0;
    end else if (cmd.classify) begin
      if (col_more) begin
        col_pos <= col_right;
      end else begin
        col_pos <= '0;
        if (row_more) begin
          row_pos <= row_inc[ROW_W-1:0];
        end else begin
          frame_complete <= 1'b1;
        end
      end
    end
  end

  // line buffers, read at the current column and its right neighbour
  always_ff @(posedge clk) begin
    mid_q   <= middle_line[col_pos];
    right_q <= middle_line[col_right];
    up_q    <= upper_line[col_pos];
    if (cmd.classify) begin
      upper_line[col_pos]  <= mid_q;
      middle_line[col_pos] <= pix;
    end
  end

  // incoming pixel colour and left neighbour
  always_ff @(posedge clk) begin
    if (cmd.take_pix) begin
      pix <= {chan0[CHAN_W-1 -: 2], chan1[CHAN_W-1 -: 2], chan2[CHAN_W-1 -: 2]};
    end
    if (cmd.classify) begin
      left_mid <= mid_q;
    end
  end

  // interior test for the middle-line pixel above the new one
  assign inner = (row_pos > ROW_W'(1)) && (col_pos != '0) && col_more &&
                 (up_q == mid_q) && (pix == mid_q) &&
                 (left_mid == mid_q) && (right_q == mid_q);
  assign addr_a = {~inner, mid_q};
  assign addr_b = {1'b1, pix};

  // histogram address and pending last-row bump
  always_ff @(posedge clk) begin
    if (cmd.take_read) begin
      hist_addr <= bin_select;
    end else if (cmd.classify) begin
      hist_addr <= (row_pos != '0) ? addr_a : addr_b;
    end else if (cmd.load_b) begin
      hist_addr <= addr_b_q;
    end
    if (cmd.classify) begin
      addr_b_q <= addr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need_b <= 1'b0;
    end else if (cmd.classify) begin
      need_b <= (row_pos != '0) && !row_more;
    end
  end

  // histogram memory, interior bins low, border bins high
  always_ff @(posedge clk) begin
    hist_q  <= hist_mem[hist_addr];
    hist_qv <= hist_valid[hist_addr];
    if (cmd.write_hist) begin
      hist_mem[hist_addr] <= hist_inc;
    end
  end

  // per-bin valid bits, an unwritten bin reads as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_hist) begin
      hist_valid <= '0;
    end else if (cmd.write_hist) begin
      hist_valid[hist_addr] <= 1'b1;
    end
  end

  // saturating increment
  assign hist_cur = hist_qv ? hist_q : '0;
  assign hist_inc = (hist_cur == COUNT_MAX) ? hist_cur : hist_cur + COUNT_W'(1);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      bin_count  <= hist_cur;
      bin_index  <= hist_addr;
      frame_done <= frame_complete;
    end
  end

  // status to controller
  always_comb begin
    sts.frame_complete = frame_complete;
    sts.row_nonzero    = (row_pos != '0);
    sts.last_row       = !row_more;
    sts.need_b         = need_b;
    sts.out_busy       = res_valid && res_stall;
  end

endmodule

`default_nettype wire

>>> src/bic_checker.sv
`default_nettype none

module bic_checker import bic_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_stall,
  input wire logic [1:0]         req_type,
  input wire logic [BIN_W-1:0]   bin_select,
  input wire logic               res_valid,
  input wire logic               res_stall,
  input wire logic [COUNT_W-1:0] bin_count,
  input wire logic [BIN_W-1:0]   bin_index,
  input wire logic               frame_done
);

  logic req_take;
  assign req_take = req_valid && !req_stall;

  // a stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(bin_count) &&
                               $stable(bin_index) && $stable(frame_done))
    else $error("stalled result changed");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // a read with a free output shows its bin after the read-wait and read-done states
  a_read_echo: assert property (@(posedge clk) disable iff (rst)
    req_take && (req_type == REQ_READ) && !res_valid
      |-> ##3 res_valid && (bin_index == $past(bin_select, 3)))
    else $error("bin read result missing or wrong index");

  // a start transaction leaves requests unstalled in the cycle after it is taken
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req_take && (req_type == REQ_START) |=> !req_stall)
    else $error("start transaction did not complete in one cycle");

endmodule

bind border_interior_color_histogram_top bic_checker u_bic_checker (.*);

`default_nettype wire
